/* hw/rtl/xbf_pkg.sv */
// Package for the xoshiro128+ byte filler: request/response payload types,
// field widths and generator constants. No dependencies.
package xbf_pkg;

   localparam int SEED_WIDTH   = 32;
   localparam int COUNT_WIDTH  = 9;
   localparam int WORD_WIDTH   = 32;
   localparam int VALID_WIDTH  = 3;

   // default byte limit per request
   localparam int MAX_BYTES_DEFAULT = 256;

   // seed expansion multiplier and xoshiro128+ shift/rotate amounts
   localparam logic [SEED_WIDTH-1:0] SEED_MULT = 32'h0000_01b1;
   localparam int GEN_SHIFT  = 9;
   localparam int GEN_ROTATE = 11;

   // bytes carried by one full output word
   localparam logic [COUNT_WIDTH-1:0] WORD_BYTES = 9'd4;

   typedef struct packed {
      logic [SEED_WIDTH-1:0]  seed;
      logic [COUNT_WIDTH-1:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0]  random_word;
      logic [VALID_WIDTH-1:0] valid_bytes;
      logic                   last;
   } rsp_type;

endpackage

/* hw/rtl/xbf_front.sv */
// Front end of the byte filler: accepts requests, saturates the byte count,
// drops zero-count requests and holds the rest in a two-entry queue.
// Depends on xbf_pkg.
module xbf_front #(
   parameter int MAX_BYTES = xbf_pkg::MAX_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  xbf_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output xbf_pkg::req_type cmd_data
);
   import xbf_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MAX_CNT = COUNT_WIDTH'(MAX_BYTES);

   req_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   logic       push_ok;
   logic       store;
   logic       take;
   req_type    entry;

   // saturate count and classify
   always_comb begin
      entry      = req_data;
      if (req_data.byte_count > MAX_CNT) begin
         entry.byte_count = MAX_CNT;
      end
      push_ok = req_push && !req_full;
      store   = push_ok && (req_data.byte_count != '0);
      take    = cmd_valid && cmd_ready;
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ store;
      rd_ptr_in = rd_ptr_ff ^ take;
      cnt_in    = cnt_ff + {1'b0, store} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (store) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

/* hw/rtl/xbf_back.sv */
// Back end of the byte filler: expands the seed into four generator words,
// runs xoshiro128+ once per output word and queues the words for the
// receiver. Depends on xbf_pkg.
module xbf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  xbf_pkg::req_type cmd_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output xbf_pkg::rsp_type rsp_data
);
   import xbf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEED = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             idx_ff, idx_in;
   logic [SEED_WIDTH-1:0]  s_ff, s_in;
   logic [COUNT_WIDTH-1:0] bytes_left_ff, bytes_left_in;
   logic [WORD_WIDTH-1:0]  gw_ff [4];
   logic [WORD_WIDTH-1:0]  gw_in [4];

   rsp_type    oq_ff [2];
   logic       owr_ptr_ff, owr_ptr_in;
   logic       ord_ptr_ff, ord_ptr_in;
   logic [1:0] ocnt_ff, ocnt_in;

   logic [SEED_WIDTH-1:0]  prod;
   logic [WORD_WIDTH-1:0]  t, n0, n1, n2, n3;
   logic                   gen;
   logic                   out_take;
   logic                   is_last;
   logic [VALID_WIDTH-1:0] take_bytes;
   rsp_type                out_entry;

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_empty = (ocnt_ff == 2'd0);
   assign rsp_data  = oq_ff[ord_ptr_ff];
   assign out_take  = rsp_pop && !rsp_empty;

   // seed chain step and generator step
   always_comb begin
      prod = s_ff * SEED_MULT + {{(SEED_WIDTH-2){1'b0}}, idx_ff};
      t    = gw_ff[1] << GEN_SHIFT;
      n2   = gw_ff[2] ^ gw_ff[0];
      n3   = gw_ff[3] ^ gw_ff[1];
      n1   = gw_ff[1] ^ n2;
      n0   = gw_ff[0] ^ n3;
      is_last    = (bytes_left_ff <= WORD_BYTES);
      take_bytes = is_last ? bytes_left_ff[VALID_WIDTH-1:0] : WORD_BYTES[VALID_WIDTH-1:0];
      out_entry.random_word = gw_ff[0] + gw_ff[3];
      out_entry.valid_bytes = take_bytes;
      out_entry.last        = is_last;
      gen = (state_ff == ST_RUN) && (ocnt_ff != 2'd2);
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      s_in          = s_ff;
      bytes_left_in = bytes_left_ff;
      for (int i = 0; i < 4; i++) begin
         gw_in[i] = gw_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               s_in          = cmd_data.seed;
               bytes_left_in = cmd_data.byte_count;
               idx_in        = 2'd0;
               state_in      = ST_SEED;
            end
         end
         ST_SEED: begin
            s_in          = prod;
            gw_in[idx_ff] = prod;
            idx_in        = idx_ff + 2'd1;
            if (idx_ff == 2'd3) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (gen) begin
               gw_in[0] = n0;
               gw_in[1] = n1;
               gw_in[2] = n2 ^ t;
               gw_in[3] = {n3[WORD_WIDTH-GEN_ROTATE-1:0],
                           n3[WORD_WIDTH-1:WORD_WIDTH-GEN_ROTATE]};
               bytes_left_in = bytes_left_ff - {{(COUNT_WIDTH-VALID_WIDTH){1'b0}}, take_bytes};
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output queue pointers
   always_comb begin
      owr_ptr_in = owr_ptr_ff ^ gen;
      ord_ptr_in = ord_ptr_ff ^ out_take;
      ocnt_in    = ocnt_ff + {1'b0, gen} - {1'b0, out_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= 2'd0;
         bytes_left_ff <= '0;
         owr_ptr_ff    <= 1'b0;
         ord_ptr_ff    <= 1'b0;
         ocnt_ff       <= 2'd0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         bytes_left_ff <= bytes_left_in;
         owr_ptr_ff    <= owr_ptr_in;
         ord_ptr_ff    <= ord_ptr_in;
         ocnt_ff       <= ocnt_in;
      end
   end

   // generator words and seed chain
   always_ff @(posedge clock) begin
      s_ff <= s_in;
      for (int i = 0; i < 4; i++) begin
         gw_ff[i] <= gw_in[i];
      end
   end

   // output queue storage
   always_ff @(posedge clock) begin
      if (gen) begin
         oq_ff[owr_ptr_ff] <= out_entry;
      end
   end

endmodule

/* hw/rtl/xoshiro128plus_byte_filler_unit.sv */
// Top level of the xoshiro128+ byte filler: front request queue feeding
// the seeding and generator back end. Depends on xbf_pkg, xbf_front, xbf_back.
//
// Usage:
//   Requests enter through req_push/req_full with req_data (seed, byte_count).
//   A request is taken when req_push is high and req_full is low. Counts above
//   MAX_BYTES are clipped to MAX_BYTES; a zero count is taken and produces
//   no response.
//   Responses leave through rsp_empty/rsp_pop: while rsp_empty is low the
//   oldest word is on rsp_data and it is taken when rsp_pop is high.
//   Each response word carries the generator output, the number of valid low
//   bytes (1..4) and a last flag on the final word of the request.
// Timing:
//   A request waits in the front queue until the back end is idle, then seed
//   expansion fills the four generator words (one constant multiply per cycle)
//   and one word is emitted per cycle while the response queue has room.
//   The front holds two requests, so the next ones queue while one runs.
//   When the receiver stalls, the two-entry response queue fills and the
//   generator pauses until room frees up; nothing is lost.
// Reset (synchronous) empties both queues and idles the generator.
module xoshiro128plus_byte_filler_unit #(
   parameter int MAX_BYTES = xbf_pkg::MAX_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  xbf_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output xbf_pkg::rsp_type rsp_data
);
   import xbf_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   req_type cmd_data;

   // request intake and queue
   xbf_front #(
      .MAX_BYTES (MAX_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data)
   );

   // seeding, generation and response queue
   xbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd_data  (cmd_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/xbf_checker.sv */
// Port-level checks for the xoshiro128+ byte filler, bound to the top level.
// Depends on xbf_pkg and xoshiro128plus_byte_filler_unit.
module xbf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input xbf_pkg::rsp_type rsp_data
);
   import xbf_pkg::*;

   // reset leaves both queues empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting response stays until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("response withdrawn before pop");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // valid byte count in range
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.valid_bytes != 3'd0 && rsp_data.valid_bytes <= 3'd4))
      else $error("valid byte count out of range");

   // only the last word of a request may be partial
   a_partial_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.last) |-> (rsp_data.valid_bytes == 3'd4))
      else $error("partial word not flagged last");

endmodule

bind xoshiro128plus_byte_filler_unit xbf_checker u_xbf_checker (.*);

/* bench/xoshiro128plus_byte_filler_unit_test.sv */
// Self-checking bench for the xoshiro128+ byte filler: directed table, then random
// requests, every response checked against an in-bench generator model or a typed word.
// Depends on xbf_pkg and xoshiro128plus_byte_filler_unit.
`timescale 1ns / 1ps

module xoshiro128plus_byte_filler_unit_test;
   import xbf_pkg::*;

   localparam int LIMIT_BYTES   = MAX_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS  = 150;
   localparam int WATCHDOG_MAX  = 2000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int DIRECTED_ROWS = 16;

   // how a directed row gets its expectation
   typedef enum logic [1:0] {
      FROM_MODEL,
      TYPED_NONE,
      TYPED_WORD
   } row_kind_type;

   typedef struct packed {
      logic [SEED_WIDTH-1:0]  seed;
      logic [COUNT_WIDTH-1:0] count;
      row_kind_type           kind;
      logic [WORD_WIDTH-1:0]  word;
   } stim_row_type;

   // seed 0 expands to w0 = 0, w3 = 0x2dfc6, so its first word is 0x2dfc6
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 9'd0,   TYPED_NONE, 32'h0},
      '{32'h0000_0000, 9'd1,   TYPED_WORD, 32'h0002_dfc6},
      '{32'hffff_ffff, 9'd0,   TYPED_NONE, 32'h0},
      '{32'hffff_ffff, 9'd1,   FROM_MODEL, 32'h0},
      '{32'hffff_ffff, 9'd2,   FROM_MODEL, 32'h0},
      '{32'hffff_ffff, 9'd3,   FROM_MODEL, 32'h0},
      '{32'hffff_ffff, 9'd4,   FROM_MODEL, 32'h0},
      '{32'h1234_5678, 9'd5,   FROM_MODEL, 32'h0},
      '{32'h8000_0000, 9'd8,   FROM_MODEL, 32'h0},
      '{32'h0000_0001, 9'd255, FROM_MODEL, 32'h0},
      '{32'h7fff_ffff, 9'd256, FROM_MODEL, 32'h0},
      '{32'ha5a5_a5a5, 9'd257, FROM_MODEL, 32'h0},
      '{32'hffff_ffff, 9'd511, FROM_MODEL, 32'h0},
      '{32'hdead_beef, 9'd0,   TYPED_NONE, 32'h0},
      '{32'hdead_beef, 9'd6,   FROM_MODEL, 32'h0},
      '{32'h0000_0000, 9'd1,   TYPED_WORD, 32'h0002_dfc6}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   bit      ready_to_run = 1'b0;
   int      fail_count   = 0;
   int      idle_cycles  = 0;

   // generator model state and the words still owed by the block
   logic [WORD_WIDTH-1:0] gen_words [4];
   rsp_type               pending_words [$];

   // response side idling
   int rsp_stall_left = 0;
   int rsp_phase_left = 0;
   bit rsp_quiet      = 1'b0;
   bit tx_quiet       = 1'b0;

   xoshiro128plus_byte_filler_unit #(
      .MAX_BYTES(LIMIT_BYTES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // one xoshiro128+ step on the model state
   function automatic logic [WORD_WIDTH-1:0] next_generator_word();
      logic [WORD_WIDTH-1:0] sum;
      logic [WORD_WIDTH-1:0] shifted;
      sum          = gen_words[0] + gen_words[3];
      shifted      = gen_words[1] << GEN_SHIFT;
      gen_words[2] = gen_words[2] ^ gen_words[0];
      gen_words[3] = gen_words[3] ^ gen_words[1];
      gen_words[1] = gen_words[1] ^ gen_words[2];
      gen_words[0] = gen_words[0] ^ gen_words[3];
      gen_words[2] = gen_words[2] ^ shifted;
      gen_words[3] = (gen_words[3] << GEN_ROTATE) | (gen_words[3] >> (WORD_WIDTH - GEN_ROTATE));
      return sum;
   endfunction

   // reseed, then generate the words one request should produce
   function automatic void expand_request(input req_type req, ref rsp_type words [$]);
      logic [SEED_WIDTH-1:0] chain;
      int                    remaining;
      int                    take;
      rsp_type               item;
      chain = req.seed;
      for (int i = 0; i < 4; i++) begin
         chain        = chain * SEED_MULT + SEED_WIDTH'(i);
         gen_words[i] = chain;
      end
      remaining = (int'(req.byte_count) > LIMIT_BYTES) ? LIMIT_BYTES : int'(req.byte_count);
      while (remaining > 0) begin
         take             = (remaining >= 4) ? 4 : remaining;
         remaining        = remaining - take;
         item.random_word = next_generator_word();
         item.valid_bytes = VALID_WIDTH'(take);
         item.last        = (remaining == 0);
         words.push_back(item);
      end
   endfunction

   function automatic int gap_length(input bit quiet);
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // mostly short counts, some long ones, a few past the limit
   function automatic logic [COUNT_WIDTH-1:0] pick_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5)  return '0;
      if (pick < 70) return COUNT_WIDTH'($urandom_range(1, 16));
      if (pick < 88) return COUNT_WIDTH'($urandom_range(17, 64));
      if (pick < 96) return COUNT_WIDTH'($urandom_range(65, 256));
      return COUNT_WIDTH'($urandom_range(257, 511));
   endfunction

   function automatic logic [SEED_WIDTH-1:0] pick_seed();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // present one request, hold it until taken, then queue its expectation
   task automatic send_request(input req_type req, input row_kind_type kind,
                               input logic [WORD_WIDTH-1:0] typed_word);
      rsp_type words [$];
      rsp_type typed;
      int      gap;
      req_push <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (req_full !== 1'b0);
      expand_request(req, words);
      case (kind)
         TYPED_NONE: ;
         TYPED_WORD: begin
            typed.random_word = typed_word;
            typed.valid_bytes = VALID_WIDTH'(1);
            typed.last        = 1'b1;
            pending_words.push_back(typed);
         end
         default: foreach (words[i]) pending_words.push_back(words[i]);
      endcase
      gap = gap_length(tx_quiet);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   function automatic void check_word(input rsp_type got);
      rsp_type want;
      if (pending_words.size() == 0) begin
         $display("%0t: unexpected response word=%h valid=%0d last=%0d",
                  $time, got.random_word, got.valid_bytes, got.last);
         fail_count++;
         return;
      end
      want = pending_words.pop_front();
      if (got.random_word !== want.random_word) begin
         $display("%0t: random_word expected %h actual %h", $time, want.random_word,
                  got.random_word);
         fail_count++;
      end
      if (got.valid_bytes !== want.valid_bytes) begin
         $display("%0t: valid_bytes expected %0d actual %0d", $time, want.valid_bytes,
                  got.valid_bytes);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
         fail_count++;
      end
   endfunction

   // response side: check popped words, then pick the next pop with random stalls
   always @(posedge clock) begin
      bit pop_next;
      if (rsp_pop && rsp_empty === 1'b0)
         check_word(rsp_data);
      pop_next = 1'b0;
      if (ready_to_run) begin
         if (rsp_phase_left == 0) begin
            rsp_phase_left = $urandom_range(20, 200);
            rsp_quiet      = ($urandom_range(0, 3) == 0);
         end
         rsp_phase_left--;
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
         end else begin
            pop_next = 1'b1;
            if (!rsp_quiet && $urandom_range(0, 3) == 0)
               rsp_stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                            : $urandom_range(1, 3);
         end
      end
      rsp_pop <= pop_next;
   end

   // watchdog: cycles without any handshake on either side
   always @(posedge clock) begin
      if (ready_to_run) begin
         if ((req_push && req_full === 1'b0) || (rsp_pop && rsp_empty === 1'b0))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no progress for %0d cycles, %0d words outstanding", $time,
                     idle_cycles, pending_words.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      req_type req;
      for (int i = 0; i < 4; i++) gen_words[i] = '0;
      repeat (4) @(posedge clock);
      reset        <= 1'b0;
      ready_to_run <= 1'b1;
      @(posedge clock);

      // directed table
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         req.seed       = DIRECTED[r].seed;
         req.byte_count = DIRECTED[r].count;
         send_request(req, DIRECTED[r].kind, DIRECTED[r].word);
      end
      req_push <= 1'b0;
      wait_for_drain();

      // random requests, with quiet stretches and one full drain midway
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
         if (n == RANDOM_ITEMS / 2) begin
            req_push <= 1'b0;
            wait_for_drain();
            @(posedge clock);
         end
         req.seed       = pick_seed();
         req.byte_count = pick_count();
         send_request(req, FROM_MODEL, '0);
      end
      req_push <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) begin
         $display("%0t: %0d expected words never arrived", $time, pending_words.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/xbf_pkg.sv
hw/rtl/xbf_front.sv
hw/rtl/xbf_back.sv
hw/rtl/xoshiro128plus_byte_filler_unit.sv
hw/rtl/xbf_checker.sv
bench/xoshiro128plus_byte_filler_unit_test.sv
